[sv/qaa_pkg.sv]
// ============================================================================
// qaa_pkg
// Shared constants, types and a helper function for the quadtree atlas allocator.
// ============================================================================
package qaa_pkg;

    localparam int MAX_LOG2_EDGE   = 12;
    localparam int NUM_LAYERS      = MAX_LOG2_EDGE + 1;
    localparam int SLOTS_PER_LAYER = 4;

    localparam int EDGE_W  = MAX_LOG2_EDGE + 1;            // edge length, up to 4096
    localparam int COORD_W = MAX_LOG2_EDGE;                // offsets
    localparam int LAYER_W = $clog2(NUM_LAYERS + 1);       // layer index and log2 values
    localparam int CNT_W   = $clog2(SLOTS_PER_LAYER + 1);  // per-layer free count
    localparam int SLOT_W  = $clog2(SLOTS_PER_LAYER);
    localparam int ROW_W   = $clog2(NUM_LAYERS - 1);       // memory row for layers 1 and up

    localparam logic [EDGE_W-1:0] MAX_EDGE = EDGE_W'(1) << MAX_LOG2_EDGE;

    // child order: top-left, top-right, bottom-left, bottom-right (bit v = child v)
    localparam logic [SLOTS_PER_LAYER-1:0] CHILD_DX = 4'b1010;
    localparam logic [SLOTS_PER_LAYER-1:0] CHILD_DY = 4'b1100;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } slot_t;

    typedef slot_t [SLOTS_PER_LAYER-1:0] row_t;

    typedef struct packed {
        logic accept;   // latch the request fields
        logic calc;     // decode request, restart or pick source layer
        logic rd;       // read the source layer's row
        logic pop;      // pop the top square of the source layer
        logic split;    // split current square into the next layer
        logic finish;   // load the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic calc_fail;   // restart, or request cannot be met
        logic pop_last;    // popped layer is the target
        logic split_last;  // this split lands on the target
        logic out_free;    // output register can take a result
    } dp_status_t;

    // smallest e with 2**e >= v (0 and 1 both give 0)
    function automatic logic [LAYER_W-1:0] ceil_log2(input logic [EDGE_W-1:0] v);
        logic [LAYER_W-1:0] r;
        r = LAYER_W'(EDGE_W);
        for (int e = EDGE_W; e >= 0; e--) begin
            if ((EDGE_W+1)'(1) << e >= {1'b0, v}) begin
                r = LAYER_W'(e);
            end
        end
        return r;
    endfunction

endpackage

[sv/qaa_datapath.sv]
// ============================================================================
// qaa_datapath
// Atlas registers, per-layer free counts, free-square row memory, split
// arithmetic and the output register.
// ============================================================================
module qaa_datapath
    import qaa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [EDGE_W-1:0]   cfg_wr_data,
    input  logic                func,
    input  logic [EDGE_W-1:0]   request_size,
    input  logic                out_stall,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          st,
    output logic                out_valid,
    output logic                granted,
    output logic [COORD_W-1:0]  offset_x,
    output logic [COORD_W-1:0]  offset_y,
    output logic [EDGE_W-1:0]   square_size
);

    logic [EDGE_W-1:0]   res_reg;
    logic [LAYER_W-1:0]  log_edge_reg;
    logic [CNT_W-1:0]    cnt_reg [NUM_LAYERS];
    logic                func_reg;
    logic [EDGE_W-1:0]   req_reg;
    logic [LAYER_W-1:0]  tar_reg;
    logic [LAYER_W-1:0]  j_reg;
    logic [EDGE_W-1:0]   size_reg;
    logic                fail_reg;
    logic [COORD_W-1:0]  x_reg;
    logic [COORD_W-1:0]  y_reg;
    row_t                rd_row_reg;
    row_t                mem [NUM_LAYERS-1];

    logic                out_valid_reg;
    logic                granted_reg;
    logic [COORD_W-1:0]  offset_x_reg;
    logic [COORD_W-1:0]  offset_y_reg;
    logic [EDGE_W-1:0]   square_size_reg;

    logic [EDGE_W-1:0]   atlas_edge;
    logic [LAYER_W-1:0]  req_log;
    logic [LAYER_W-1:0]  tar_calc;
    logic                bad_req;
    logic                hit;
    logic                found;
    logic [LAYER_W-1:0]  src_calc;
    logic [EDGE_W-1:0]   res_clamped;
    logic [LAYER_W-1:0]  j_plus1;
    logic [LAYER_W-1:0]  half_sh;
    logic [COORD_W-1:0]  half;
    logic [CNT_W-1:0]    cnt_j;
    logic [SLOT_W-1:0]   pop_slot;
    slot_t               pop_sq;
    row_t                child_row;

    assign atlas_edge  = EDGE_W'(1) << log_edge_reg;
    assign req_log     = ceil_log2(req_reg);
    assign tar_calc    = log_edge_reg - req_log;
    assign bad_req     = (req_reg == '0) || (req_reg > atlas_edge);
    assign res_clamped = (res_reg > MAX_EDGE) ? MAX_EDGE : res_reg;

    // target hit, else nearest shallower layer holding a free square
    always_comb
    begin
        hit      = 1'b0;
        found    = 1'b0;
        src_calc = tar_calc;
        for (int i = 0; i < NUM_LAYERS; i++) begin
            if (LAYER_W'(i) == tar_calc && cnt_reg[i] != '0) begin
                hit = 1'b1;
            end
            if (LAYER_W'(i) < tar_calc && cnt_reg[i] != '0) begin
                found = 1'b1;
            end
        end
        if (!hit) begin
            for (int i = 0; i < NUM_LAYERS; i++) begin
                if (LAYER_W'(i) < tar_calc && cnt_reg[i] != '0) begin
                    src_calc = LAYER_W'(i);
                end
            end
        end
    end

    assign j_plus1  = j_reg + LAYER_W'(1);
    assign half_sh  = log_edge_reg - j_plus1;
    assign half     = COORD_W'(EDGE_W'(1) << half_sh);
    assign cnt_j    = cnt_reg[j_reg];
    assign pop_slot = SLOT_W'(cnt_j - CNT_W'(1));
    // layer 0 only ever holds the whole atlas at the origin
    assign pop_sq   = (j_reg == '0) ? '0 : rd_row_reg[pop_slot];

    always_comb
    begin
        for (int v = 0; v < SLOTS_PER_LAYER; v++) begin
            child_row[v].x = x_reg + (CHILD_DX[v] ? half : '0);
            child_row[v].y = y_reg + (CHILD_DY[v] ? half : '0);
        end
    end

    assign st.calc_fail  = func_reg || bad_req || (!hit && !found);
    assign st.pop_last   = (j_reg == tar_reg);
    assign st.split_last = (j_plus1 == tar_reg);
    assign st.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_reg      <= MAX_EDGE;
            log_edge_reg <= LAYER_W'(MAX_LOG2_EDGE);
            for (int i = 0; i < NUM_LAYERS; i++) begin
                cnt_reg[i] <= (i == 0) ? CNT_W'(1) : '0;
            end
        end else begin
            if (cfg_wr_en) begin
                res_reg <= cfg_wr_data;
            end
            if (cmd.calc && func_reg) begin
                log_edge_reg <= ceil_log2(res_clamped);
                for (int i = 0; i < NUM_LAYERS; i++) begin
                    cnt_reg[i] <= (i == 0) ? CNT_W'(1) : '0;
                end
            end else if (cmd.pop) begin
                cnt_reg[j_reg] <= cnt_j - CNT_W'(1);
            end else if (cmd.split) begin
                // four children pushed, bottom-right popped again at once
                cnt_reg[j_plus1] <= CNT_W'(SLOTS_PER_LAYER - 1);
            end
        end
    end

    // request and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept) begin
            func_reg <= func;
            req_reg  <= request_size;
        end
        if (cmd.calc) begin
            tar_reg  <= tar_calc;
            j_reg    <= src_calc;
            size_reg <= EDGE_W'(1) << req_log;
            fail_reg <= st.calc_fail;
        end else if (cmd.pop) begin
            x_reg <= pop_sq.x;
            y_reg <= pop_sq.y;
        end else if (cmd.split) begin
            x_reg <= child_row[SLOTS_PER_LAYER-1].x;
            y_reg <= child_row[SLOTS_PER_LAYER-1].y;
            j_reg <= j_plus1;
        end
    end

    // free-square rows, one row per layer from layer 1 on
    always_ff @(posedge clk)
    begin
        if (cmd.split) begin
            mem[j_reg[ROW_W-1:0]] <= child_row;
        end
        if (cmd.rd && j_reg != '0) begin
            rd_row_reg <= mem[ROW_W'(j_reg - LAYER_W'(1))];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish) begin
            granted_reg     <= !fail_reg;
            offset_x_reg    <= fail_reg ? '0 : x_reg;
            offset_y_reg    <= fail_reg ? '0 : y_reg;
            square_size_reg <= fail_reg ? '0 : size_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign granted     = granted_reg;
    assign offset_x    = offset_x_reg;
    assign offset_y    = offset_y_reg;
    assign square_size = square_size_reg;

endmodule

[sv/qaa_ctrl.sv]
// ============================================================================
// qaa_ctrl
// Sequencer: accept, decode, fetch source row, pop, split down, deliver.
// ============================================================================
module qaa_ctrl
    import qaa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  dp_status_t  st,
    output ctrl_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_SPLIT = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = st.calc_fail ? S_FIN : S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_POP;
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = st.pop_last ? S_FIN : S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.split = 1'b1;
                if (st.split_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (st.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

[sv/quadtree_atlas_allocator_top.sv]
// ============================================================================
// quadtree_atlas_allocator_top
// Square atlas allocator on a 2D buddy quadtree with per-layer free stacks.
// ============================================================================
// Sequence: a restart or failed request goes from decode to the output register;
//   a grant reads the source row, pops, then splits down a layer at a time to the target.
// Requests: one in flight at a time; the next request is taken once
//   the sequencer is back in idle, while the previous result may still wait.
// Reset: atlas edge 4096, one free square (whole atlas) at layer 0.
module quadtree_atlas_allocator_top
    import qaa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [EDGE_W-1:0]   cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic [EDGE_W-1:0]   request_size,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                granted,
    output logic [COORD_W-1:0]  offset_x,
    output logic [COORD_W-1:0]  offset_y,
    output logic [EDGE_W-1:0]   square_size
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    qaa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    qaa_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .func         (func),
        .request_size (request_size),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .granted      (granted),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .square_size  (square_size)
    );

endmodule

[sv/qaa_checker.sv]
// ============================================================================
// qaa_checker
// Port-level checks on the allocator, bound to the top level.
// ============================================================================
module qaa_checker
    import qaa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                granted,
    input  logic [COORD_W-1:0]  offset_x,
    input  logic [COORD_W-1:0]  offset_y,
    input  logic [EDGE_W-1:0]   square_size
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // one request in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken during processing");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> offset_x == '0 && offset_y == '0 && square_size == '0)
        else $error("failed result carries nonzero fields");

    a_size_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && granted |-> $onehot(square_size))
        else $error("granted size not a power of two");

    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && granted |->
            ((EDGE_W'(offset_x) | EDGE_W'(offset_y)) & (square_size - EDGE_W'(1))) == '0)
        else $error("granted square not aligned to its size");

endmodule

bind quadtree_atlas_allocator_top qaa_checker u_qaa_checker (.*);
